// File: rtl/lru_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_pkg
// Shared constants, state type and controller commands for the LRU page
// replacement core.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int unsigned LRU_FRAMES = 16;
  localparam int unsigned LRU_PAGE_W = 8;
  localparam int unsigned LRU_CNT_W  = 5;

  localparam logic [LRU_CNT_W-1:0] LRU_FC_RESET = 5'd4;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } lru_state_e;

  typedef struct packed {
    logic load;
    logic commit;
  } lru_cmd_t;

endpackage
`default_nettype wire

// File: rtl/lru_page_replacement_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// Least-recently-used page replacement: one page reference in, one hit or
// fault report out, with the evicted page when a full set must give one up.
// ----------------------------------------------------------------------------
// Each reference first latches the page, then compares it against all
// resident pages of the recency stack in parallel and updates the stack
// and occupancy. The finished result sits in an output register, so the
// next word is taken while it waits; a new result stalls only if the previous
// one has not yet been taken. Residency is the set of valid stack entries, so
// no per-page map or clearing pass is needed. frame_count (reset 4) is read
// as 1 when zero and as FRAMES when larger; lowering it drops no page.
// ----------------------------------------------------------------------------
module lru_page_replacement_core
  import lru_pkg::*;
#(
  parameter int unsigned FRAMES = LRU_FRAMES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LRU_CNT_W-1:0]  cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [LRU_PAGE_W-1:0] page_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_hit_o,
  output logic                  evicted_valid_o,
  output logic [LRU_PAGE_W-1:0] evicted_page_o,
  output logic [LRU_CNT_W-1:0]  occupied_o
);

  lru_cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  lru_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .page_i          (page_i),
    .is_hit_o        (is_hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .occupied_o      (occupied_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while lookup pending");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(occupied_o) <= FRAMES) && (occupied_o != '0))
    else $error("occupancy out of range");

  a_evict_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_valid_o |-> !is_hit_o)
    else $error("eviction reported on a hit");

endmodule
`default_nettype wire

// File: rtl/lru_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_ctrl
// Sequencer: takes a word in idle, runs the lookup cycle and hands the
// result to the output register when it is free.
// ----------------------------------------------------------------------------
module lru_ctrl
  import lru_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lru_cmd_t cmd_o
);

  lru_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LOOKUP: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/lru_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_dp
// Recency stack with parallel compare, frame count register, occupancy
// counter and result register.
// ----------------------------------------------------------------------------
module lru_dp
  import lru_pkg::*;
#(
  parameter int unsigned FRAMES = LRU_FRAMES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lru_cmd_t              cmd_i,
  input  logic                  cfg_we_i,
  input  logic [LRU_CNT_W-1:0]  cfg_data_i,
  input  logic [LRU_PAGE_W-1:0] page_i,
  output logic                  is_hit_o,
  output logic                  evicted_valid_o,
  output logic [LRU_PAGE_W-1:0] evicted_page_o,
  output logic [LRU_CNT_W-1:0]  occupied_o
);

  localparam int unsigned OW = $clog2(FRAMES + 1);
  localparam int unsigned LW = (OW > LRU_CNT_W) ? OW : LRU_CNT_W;

  logic [LRU_CNT_W-1:0]  fc_q;
  logic [OW-1:0]         occ_q, occ_d, wr_pos;
  logic [LRU_PAGE_W-1:0] page_q;
  logic [LRU_PAGE_W-1:0] order_q [FRAMES];
  logic [LRU_PAGE_W-1:0] order_d [FRAMES];
  logic [FRAMES-1:0]     match, shift;
  logic [LW-1:0]         fc_ext, lim;
  logic                  hit, full, remove;

  always_comb begin
    fc_ext = LW'(fc_q);
    if (fc_ext == '0) begin
      lim = LW'(1);
    end else if (fc_ext > LW'(FRAMES)) begin
      lim = LW'(FRAMES);
    end else begin
      lim = fc_ext;
    end
  end

  always_comb begin
    for (int j = 0; j < FRAMES; j++) begin
      match[j] = (OW'(j) < occ_q) && (order_q[j] == page_q);
    end
  end

  assign hit    = |match;
  assign full   = LW'(occ_q) >= lim;
  assign remove = hit || full;
  assign occ_d  = remove ? occ_q : occ_q + OW'(1);
  assign wr_pos = occ_d - OW'(1);

  // entries at and above the removed slot move one toward the front
  always_comb begin
    for (int j = 0; j < FRAMES; j++) begin
      shift[j] = !hit || (|(match & ({FRAMES{1'b1}} >> (FRAMES - 1 - j))));
    end
  end

  always_comb begin
    for (int j = 0; j < FRAMES; j++) begin
      order_d[j] = order_q[j];
      if (remove && shift[j] && (j + 1 < FRAMES)) begin
        order_d[j] = order_q[(j + 1) % FRAMES];
      end
      if (OW'(j) == wr_pos) order_d[j] = page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q  <= LRU_FC_RESET;
      occ_q <= '0;
    end else begin
      if (cfg_we_i) fc_q <= cfg_data_i;
      if (cmd_i.commit) occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) page_q <= page_i;
    if (cmd_i.commit) begin
      for (int j = 0; j < FRAMES; j++) order_q[j] <= order_d[j];
      is_hit_o        <= hit;
      evicted_valid_o <= !hit && full;
      evicted_page_o  <= (!hit && full) ? order_q[0] : '0;
      occupied_o      <= LRU_CNT_W'(occ_d);
    end
  end

endmodule
`default_nettype wire
